// ===== hw/rtl/complex_multilook_decimator_assert.svh =====
// Assertion macros used by the multilook decimator RTL.
`ifndef COMPLEX_MULTILOOK_DECIMATOR_ASSERT_SVH
`define COMPLEX_MULTILOOK_DECIMATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CMLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CMLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cmld_pkg.sv =====
// Types, constants and helper functions of the multilook decimator.
package cmld_pkg;

    localparam int MAX_LINE_WIDTH  = 16384;
    localparam int MAX_OUT_COLUMNS = 8192;

    localparam int SAMPLE_W = 16;
    localparam int LW_W     = 15;
    localparam int RS_W     = 2;
    localparam int AS_W     = 3;
    localparam int CC_W     = 14;
    localparam int GC_W     = 3;
    localparam int RIG_W    = 4;
    localparam int COL_W    = $clog2(MAX_OUT_COLUMNS);
    localparam int OC_W     = COL_W + 1;
    localparam int RSUM_W   = 19;
    localparam int CSUM_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH    = 2'd0,
        CFG_RANGE_SHIFT   = 2'd1,
        CFG_AZIMUTH_SHIFT = 2'd2
    } cmld_cfg_idx_t;

    // Work for the column stage produced by one accepted sample.
    typedef struct packed {
        logic signed [RSUM_W-1:0] sum_re;
        logic signed [RSUM_W-1:0] sum_im;
        logic [RS_W-1:0]          rshift;
        logic [AS_W-1:0]          ashift;
        logic [COL_W-1:0]         col;
        logic                     first;
        logic                     wr;
        logic                     emit;
        logic                     last;
    } cmld_cmd_t;

    // Arithmetic shift right that rounds toward zero, as a signed divide by 2^sh.
    function automatic logic signed [CSUM_W-1:0] trunc_shift(
        input logic signed [CSUM_W-1:0] v,
        input logic [AS_W-1:0]          sh
    );
        logic [CSUM_W-1:0] bias;
        bias = v[CSUM_W-1] ? ((CSUM_W'(1) << sh) - CSUM_W'(1)) : '0;
        return (v + $signed(bias)) >>> sh;
    endfunction

endpackage

// ===== hw/rtl/cmld_sample_if.sv =====
// Input sample channel of the multilook decimator.
interface cmld_sample_if;
    import cmld_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_real;
    logic signed [SAMPLE_W-1:0] in_imag;
    logic                       frame_start;

    modport source (output valid, in_real, in_imag, frame_start, input ready);
    modport sink   (input valid, in_real, in_imag, frame_start, output ready);
endinterface

// ===== hw/rtl/cmld_pixel_if.sv =====
// Output pixel channel of the multilook decimator.
interface cmld_pixel_if;
    import cmld_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_real;
    logic signed [SAMPLE_W-1:0] out_imag;
    logic                       row_end;

    modport source (output valid, out_real, out_imag, row_end, input ready);
    modport sink   (input valid, out_real, out_imag, row_end, output ready);
endinterface

// ===== hw/rtl/cmld_cfg_if.sv =====
// Configuration write channel of the multilook decimator.
interface cmld_cfg_if;
    import cmld_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cmld_ctrl.sv =====
// Configuration registers, raster counters and range summing.
module cmld_ctrl
    import cmld_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       accept,
    input  logic signed [SAMPLE_W-1:0] in_real,
    input  logic signed [SAMPLE_W-1:0] in_imag,
    input  logic                       frame_start,
    output cmld_cmd_t                  cmd
);

    logic [LW_W-1:0]          line_width_reg;
    logic [RS_W-1:0]          range_shift_reg;
    logic [AS_W-1:0]          azimuth_shift_reg;
    logic signed [RSUM_W-1:0] range_sum_re_reg, range_sum_im_reg;
    logic [CC_W-1:0]          column_count_reg;
    logic [GC_W-1:0]          group_count_reg;
    logic [RIG_W-1:0]         row_in_group_reg;
    logic [OC_W-1:0]          out_column_reg;

    logic signed [RSUM_W-1:0] range_sum_re_next, range_sum_im_next;
    logic [CC_W-1:0]          column_count_next;
    logic [GC_W-1:0]          group_count_next;
    logic [RIG_W-1:0]         row_in_group_next;
    logic [OC_W-1:0]          out_column_next;

    logic [RS_W-1:0]  rs_eff;
    logic [AS_W-1:0]  as_eff;
    logic [GC_W:0]    rlook;
    logic [RIG_W:0]   alook;
    logic [LW_W-1:0]  width;
    logic [OC_W-1:0]  ncols;
    logic [CC_W-1:0]  cc0;
    logic [GC_W-1:0]  gc0;
    logic [RIG_W-1:0] rig0;
    logic [OC_W-1:0]  oc0;
    logic [LW_W-1:0]  cc1;
    logic [GC_W:0]    gc1;
    logic [RIG_W:0]   rig1;
    logic             complete;
    logic             hit;
    logic             last_row;
    logic             row_done;

    always_comb
    begin
        rs_eff = (range_shift_reg == '0) ? RS_W'(1) : range_shift_reg;
        if (azimuth_shift_reg == '0)
        begin
            as_eff = AS_W'(1);
        end
        else if (azimuth_shift_reg > AS_W'(4))
        begin
            as_eff = AS_W'(4);
        end
        else
        begin
            as_eff = azimuth_shift_reg;
        end
        rlook = (GC_W+1)'(1) << rs_eff;
        alook = (RIG_W+1)'(1) << as_eff;

        width = (line_width_reg > LW_W'(MAX_LINE_WIDTH)) ? LW_W'(MAX_LINE_WIDTH)
                                                         : line_width_reg;
        if (width == '0)
        begin
            width = LW_W'(1);
        end
        ncols = OC_W'(width >> rs_eff);

        cc0  = frame_start ? '0 : column_count_reg;
        gc0  = frame_start ? '0 : group_count_reg;
        rig0 = frame_start ? '0 : row_in_group_reg;
        oc0  = frame_start ? '0 : out_column_reg;

        if (gc0 == '0)
        begin
            range_sum_re_next = RSUM_W'(in_real);
            range_sum_im_next = RSUM_W'(in_imag);
        end
        else
        begin
            range_sum_re_next = range_sum_re_reg + RSUM_W'(in_real);
            range_sum_im_next = range_sum_im_reg + RSUM_W'(in_imag);
        end

        gc1      = {1'b0, gc0} + (GC_W+1)'(1);
        complete = (gc1 >= rlook);
        hit      = complete && (oc0 < ncols);
        rig1     = {1'b0, rig0} + (RIG_W+1)'(1);
        last_row = (rig1 >= alook);

        group_count_next = complete ? '0 : gc1[GC_W-1:0];
        out_column_next  = oc0;
        if (complete && (oc0 < OC_W'(MAX_OUT_COLUMNS)))
        begin
            out_column_next = oc0 + OC_W'(1);
        end

        cc1               = {1'b0, cc0} + LW_W'(1);
        row_done          = (cc1 >= width);
        column_count_next = cc1[CC_W-1:0];
        row_in_group_next = rig0;
        if (row_done)
        begin
            column_count_next = '0;
            group_count_next  = '0;
            out_column_next   = '0;
            row_in_group_next = last_row ? '0 : rig1[RIG_W-1:0];
        end

        cmd.sum_re = range_sum_re_next;
        cmd.sum_im = range_sum_im_next;
        cmd.rshift = rs_eff;
        cmd.ashift = as_eff;
        cmd.col    = oc0[COL_W-1:0];
        cmd.first  = (rig0 == '0);
        cmd.wr     = hit;
        cmd.emit   = hit && last_row;
        cmd.last   = ((oc0 + OC_W'(1)) == ncols);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg    <= LW_W'(MAX_LINE_WIDTH);
            range_shift_reg   <= RS_W'(1);
            azimuth_shift_reg <= AS_W'(1);
            range_sum_re_reg  <= '0;
            range_sum_im_reg  <= '0;
            column_count_reg  <= '0;
            group_count_reg   <= '0;
            row_in_group_reg  <= '0;
            out_column_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LINE_WIDTH:    line_width_reg    <= cfg_data[LW_W-1:0];
                    CFG_RANGE_SHIFT:   range_shift_reg   <= cfg_data[RS_W-1:0];
                    CFG_AZIMUTH_SHIFT: azimuth_shift_reg <= cfg_data[AS_W-1:0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                range_sum_re_reg <= range_sum_re_next;
                range_sum_im_reg <= range_sum_im_next;
                column_count_reg <= column_count_next;
                group_count_reg  <= group_count_next;
                row_in_group_reg <= row_in_group_next;
                out_column_reg   <= out_column_next;
            end
        end
    end

endmodule

// ===== hw/rtl/cmld_colacc.sv =====
// Column line store with read-modify-write stage and output register.
`include "complex_multilook_decimator_assert.svh"

module cmld_colacc
    import cmld_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  cmld_cmd_t                  cmd,
    output logic                       stage_ready,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] out_real,
    output logic signed [SAMPLE_W-1:0] out_imag,
    output logic                       row_end
);

    logic [2*CSUM_W-1:0] line_mem [MAX_OUT_COLUMNS];

    cmld_cmd_t                  s1_cmd_reg;
    logic                       s1_valid_reg;
    logic [2*CSUM_W-1:0]        rd_data_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_real_reg, out_imag_reg;
    logic                       row_end_reg;

    logic                       s1_move;
    logic signed [CSUM_W-1:0]   avg_re, avg_im;
    logic signed [CSUM_W-1:0]   acc_re, acc_im;
    logic signed [CSUM_W-1:0]   div_re, div_im;

    assign s1_move     = s1_valid_reg && (!s1_cmd_reg.emit || !out_valid_reg || out_ready);
    assign stage_ready = !s1_valid_reg || s1_move;

    always_comb
    begin
        avg_re = trunc_shift({{(CSUM_W-RSUM_W){s1_cmd_reg.sum_re[RSUM_W-1]}},
                              s1_cmd_reg.sum_re}, {1'b0, s1_cmd_reg.rshift});
        avg_im = trunc_shift({{(CSUM_W-RSUM_W){s1_cmd_reg.sum_im[RSUM_W-1]}},
                              s1_cmd_reg.sum_im}, {1'b0, s1_cmd_reg.rshift});
        if (s1_cmd_reg.first)
        begin
            acc_re = avg_re;
            acc_im = avg_im;
        end
        else
        begin
            acc_re = $signed(rd_data_reg[2*CSUM_W-1:CSUM_W]) + avg_re;
            acc_im = $signed(rd_data_reg[CSUM_W-1:0]) + avg_im;
        end
        div_re = trunc_shift(acc_re, s1_cmd_reg.ashift);
        div_im = trunc_shift(acc_im, s1_cmd_reg.ashift);
    end

    // Store read at acceptance, write when the stage hands its item on.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[cmd.col];
        end
        if (s1_move)
        begin
            line_mem[s1_cmd_reg.col] <= {acc_re, acc_im};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && cmd.wr)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move && s1_cmd_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.wr)
        begin
            s1_cmd_reg <= cmd;
        end
        if (s1_move && s1_cmd_reg.emit)
        begin
            out_real_reg <= div_re[SAMPLE_W-1:0];
            out_imag_reg <= div_im[SAMPLE_W-1:0];
            row_end_reg  <= s1_cmd_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_real  = out_real_reg;
    assign out_imag  = out_imag_reg;
    assign row_end   = row_end_reg;

    `CMLD_ASSERT_IMP(a_emit_is_written, s1_valid_reg && s1_cmd_reg.emit, s1_cmd_reg.wr && !s1_cmd_reg.first, "emitting item does not accumulate into the store")
    `CMLD_ASSERT_NXT(a_stage_holds, s1_valid_reg && !s1_move, s1_valid_reg && $stable(s1_cmd_reg), "stalled stage item was lost or changed")
    `CMLD_ASSERT_NXT(a_result_has_source, !(s1_move && s1_cmd_reg.emit) && !out_valid_reg, !out_valid_reg, "result appeared without an emitting item")

endmodule

// ===== hw/rtl/complex_multilook_decimator.sv =====
// Top level of the complex multilook box-average decimator.
//
//   Channel   Direction  Payload                              Handshake
//   sample    sink       in_real, in_imag, frame_start        valid / ready
//   pixel     source     out_real, out_imag, row_end          valid / ready
//   cfg       sink       index (2 bit), data (15 bit)         valid / ready, always ready
//
// One sample is taken per clock cycle as long as the pixel side keeps up.
// A column result passes through the accumulate stage register into the output
// register. The line store is read at acceptance and written back as that stage
// hands its item on. The store holds no reset value and needs no clearing pass,
// so the block takes samples from the first cycle after reset. A stall on the
// pixel side backs up only through the single accumulate stage.
module complex_multilook_decimator
    import cmld_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cmld_sample_if.sink    sample,
    cmld_pixel_if.source   pixel,
    cmld_cfg_if.sink       cfg
);

    // Transfer strobes for the two write-side channels.
    logic      accept;
    logic      cfg_we;
    logic      stage_ready;
    cmld_cmd_t cmd;

    // Configuration writes never stall: the registers take any transfer at once.
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // A sample is taken whenever the accumulate stage is empty or handing off
    // its item in the same cycle. Samples that finish no column never occupy
    // the stage, so they are only blocked behind a stalled result.
    assign sample.ready = stage_ready;
    assign accept       = sample.valid && sample.ready;

    // Counters and range sums run at the acceptance edge and describe the
    // column work, if any, that the sample completes.
    cmld_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .accept      (accept),
        .in_real     (sample.in_real),
        .in_imag     (sample.in_imag),
        .frame_start (sample.frame_start),
        .cmd         (cmd)
    );

    // The column stage averages the range sum, accumulates it into the line
    // store over the azimuth rows, and divides on the last row of the group.
    cmld_colacc u_colacc (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .stage_ready (stage_ready),
        .out_ready   (pixel.ready),
        .out_valid   (pixel.valid),
        .out_real    (pixel.out_real),
        .out_imag    (pixel.out_imag),
        .row_end     (pixel.row_end)
    );

endmodule
